// File: sv/dfv_pkg.sv
`default_nettype none

package dfv_pkg;

  // Fixed point with FRAC_W fraction bits, signed but for mobility and spacing.
  localparam int VALUE_W = 48;
  localparam int FRAC_W  = 24;
  localparam int MOB_W   = VALUE_W - 1;
  localparam int DIFF_W  = VALUE_W + 1;
  localparam int FUNC_W  = 3;
  localparam int SIDE_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Widths of the exact intermediate products.
  localparam int SHIFT_T = 2 * FRAC_W + 1;
  localparam int P1_W    = VALUE_W + MOB_W;
  localparam int P2_W    = P1_W + DIFF_W;
  localparam int TMAG_W  = P2_W + 1;
  localparam int TS_W    = TMAG_W + 1;
  localparam int N_W     = VALUE_W + TMAG_W;
  localparam int PRE_W   = N_W + 1 - SHIFT_T;
  localparam int HNUM_W  = 2 * MOB_W + 1;
  localparam int QUO_W   = VALUE_W;

  // Multiplier digit size and latency.
  localparam int MUL_DIG = 24;
  localparam int MUL_LAT = 3;

  localparam logic [FUNC_W-1:0] FUNC_INT_X     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INT_Y     = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INT_Z     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIRICHLET = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_FLUX      = 3'd4;

  localparam logic [SIDE_W-1:0] SIDE_LEFT  = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_DOWN  = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_UP    = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_BACK  = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_FRONT = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 2'd3;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_INTERIOR,
    KIND_DIRICHLET,
    KIND_FLUX
  } kind_t;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [SIDE_W-1:0]         boundary_side;
    logic [MOB_W-1:0]          mobility_lower;
    logic [MOB_W-1:0]          mobility_upper;
    logic signed [VALUE_W-1:0] pressure_lower;
    logic signed [VALUE_W-1:0] pressure_upper;
    logic signed [VALUE_W-1:0] density_lower;
    logic signed [VALUE_W-1:0] density_upper;
    logic signed [VALUE_W-1:0] boundary_value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] face_velocity;
    logic                      saturated;
  } out_t;

  // One classified face request as it waits between front and back.
  typedef struct packed {
    kind_t                     kind;
    logic [MOB_W-1:0]          spacing;
    logic [MOB_W-1:0]          mob_lo;
    logic [MOB_W-1:0]          mob_up;
    logic signed [DIFF_W-1:0]  dp;
    logic signed [DIFF_W-1:0]  ds;
    logic                      dbl;
    logic                      negate;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

// File: sv/dfv_mul.sv
`default_nettype none

module dfv_mul #(
  parameter int AW = 48,
  parameter int BW = 48
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic [AW+BW-1:0]   p
);

  localparam int DG  = dfv_pkg::MUL_DIG;
  localparam int NA  = (AW + DG - 1) / DG;
  localparam int NB  = (BW + DG - 1) / DG;
  localparam int AEW = NA * DG;
  localparam int BEW = NB * DG;
  localparam int PW  = AW + BW;

  logic [AEW-1:0]  a_ext;
  logic [BEW-1:0]  b_ext;
  logic [2*DG-1:0] pp_r [NA][NB];
  logic [PW-1:0]   row_nxt [NA];
  logic [PW-1:0]   row_r [NA];
  logic [PW-1:0]   p_nxt;
  logic [PW-1:0]   p_r;

  assign a_ext = AEW'(a);
  assign b_ext = BEW'(b);

  // Digit products, then row sums, then the final sum of rows.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= a_ext[i*DG +: DG] * b_ext[j*DG +: DG];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (PW'(pp_r[i][j]) << (j * DG));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= row_nxt;
    end
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      p_nxt = p_nxt + (row_r[i] << (i * DG));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// File: sv/dfv_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage. The caller guarantees
// that the quotient fits in QW bits whenever the result is used.
module dfv_div #(
  parameter int NW = 96,
  parameter int DW = 48,
  parameter int QW = 48
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] n,
  input  wire logic [DW-1:0] d,
  output logic [QW-1:0]      q
);

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_in = DW'(n >> QW);
      assign den_in = d;
      assign low_in = n[QW-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign low_in = low_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        den_r[s] <= den_in;
        low_r[s] <= {low_in[QW-2:0], 1'b0};
        quo_r[s] <= {quo_in[QW-2:0], take};
      end
    end
  end

  assign q = quo_r[QW-1];

endmodule

`default_nettype wire

// File: sv/dfv_queue.sv
`default_nettype none

module dfv_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire dfv_pkg::entry_t push_data,
  input  wire logic            pop,
  output dfv_pkg::entry_t      head,
  output logic                 empty,
  output logic                 full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dfv_pkg::entry_t slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign empty = count_r == '0;
  assign full  = count_r == CW'(DEPTH);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> !empty)
    else $error("queue lost a written request");

endmodule

`default_nettype wire

// File: sv/dfv_front.sv
`default_nettype none

// Accepts face requests and classifies them into the operands of the
// common formula  M * 2^dbl * (2^(2F+1)*dp + ds*g*h) / (2^(2F+1)*h).
module dfv_front (
  input  wire logic                         in_valid,
  input  wire dfv_pkg::in_t                 in_data,
  input  wire logic [dfv_pkg::MOB_W-1:0]    spacing_x,
  input  wire logic [dfv_pkg::MOB_W-1:0]    spacing_y,
  input  wire logic [dfv_pkg::MOB_W-1:0]    spacing_z,
  input  wire logic                         full,
  output logic                              in_stall,
  output logic                              push,
  output dfv_pkg::entry_t                   entry
);

  localparam int DW = dfv_pkg::DIFF_W;

  logic signed [DW-1:0] pl_e, pu_e, dl_e, du_e, bv_e;

  assign in_stall = full;
  assign push     = in_valid && !full;

  assign pl_e = DW'(in_data.pressure_lower);
  assign pu_e = DW'(in_data.pressure_upper);
  assign dl_e = DW'(in_data.density_lower);
  assign du_e = DW'(in_data.density_upper);
  assign bv_e = DW'(in_data.boundary_value);

  always_comb begin
    entry         = '0;
    entry.kind    = dfv_pkg::KIND_NONE;
    entry.mob_lo  = in_data.mobility_lower;
    entry.mob_up  = in_data.mobility_upper;
    entry.value   = in_data.boundary_value;
    entry.spacing = spacing_x;
    case (in_data.func)
      dfv_pkg::FUNC_INT_X, dfv_pkg::FUNC_INT_Y, dfv_pkg::FUNC_INT_Z: begin
        entry.kind   = dfv_pkg::KIND_INTERIOR;
        entry.dp     = pu_e - pl_e;
        entry.negate = 1'b1;
        if (in_data.func == dfv_pkg::FUNC_INT_Y) begin
          entry.spacing = spacing_y;
        end else if (in_data.func == dfv_pkg::FUNC_INT_Z) begin
          entry.spacing = spacing_z;
          entry.ds      = du_e + dl_e;
        end
      end
      dfv_pkg::FUNC_DIRICHLET: begin
        entry.kind = dfv_pkg::KIND_DIRICHLET;
        entry.dbl  = 1'b1;
        case (in_data.boundary_side)
          dfv_pkg::SIDE_LEFT: begin
            entry.dp = bv_e - pl_e;
          end
          dfv_pkg::SIDE_RIGHT: begin
            entry.dp = pl_e - bv_e;
          end
          dfv_pkg::SIDE_DOWN: begin
            entry.spacing = spacing_y;
            entry.dp      = bv_e - pl_e;
          end
          dfv_pkg::SIDE_UP: begin
            entry.spacing = spacing_y;
            entry.dp      = pl_e - bv_e;
          end
          dfv_pkg::SIDE_BACK: begin
            entry.spacing = spacing_z;
            entry.dp      = bv_e - pl_e;
            entry.ds      = -dl_e;
          end
          dfv_pkg::SIDE_FRONT: begin
            entry.spacing = spacing_z;
            entry.dp      = pl_e - bv_e;
            entry.ds      = dl_e;
          end
          default: begin
            entry.kind = dfv_pkg::KIND_NONE;
          end
        endcase
      end
      dfv_pkg::FUNC_FLUX: begin
        entry.kind = dfv_pkg::KIND_FLUX;
      end
      default: begin
        entry.kind = dfv_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/dfv_back.sv
`default_nettype none

// Arithmetic pipeline. All stages move together whenever the output
// register can take a new result.
module dfv_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dfv_pkg::entry_t               head,
  input  wire logic                          head_valid,
  output logic                               pop,
  input  wire logic signed [dfv_pkg::VALUE_W-1:0] gravity,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output dfv_pkg::out_t                      out_data
);

  localparam int VW     = dfv_pkg::VALUE_W;
  localparam int MW     = dfv_pkg::MOB_W;
  localparam int FW_D   = dfv_pkg::DIFF_W;
  localparam int QW     = dfv_pkg::QUO_W;
  localparam int ML     = dfv_pkg::MUL_LAT;
  localparam int S_TC   = 2 * ML + 1;
  localparam int S_TM   = S_TC + 1;
  localparam int S_H    = ML + QW;
  localparam int S_N    = S_H + ML;
  localparam int S_PRE  = S_N + 1;
  localparam int S_Q    = S_PRE + QW;

  localparam logic [VW-1:0] LIM_POS = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] LIM_NEG = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic                          neg;
    logic [dfv_pkg::TMAG_W-1:0]    mag;
  } tval_t;

  typedef struct packed {
    logic nz;
    logic sgn;
  } flag_t;

  logic            adv;
  logic            vld_r [0:S_Q];
  dfv_pkg::entry_t ent_r [0:S_Q];
  tval_t           tl_r  [S_TM:S_N];
  flag_t           fl_r  [S_PRE:S_Q];
  logic            ov_r  [S_PRE+1:S_Q];

  logic                             g_neg;
  logic [VW-1:0]                    g_mag;
  logic                             ds_neg;
  logic [FW_D-1:0]                  ds_mag;
  logic [2*MW-1:0]                  mlmu;
  logic [dfv_pkg::P1_W-1:0]         p1;
  logic [dfv_pkg::P2_W-1:0]         p2;
  logic signed [dfv_pkg::TS_W-1:0]  dp_s, p2_s, tc_nxt, tc_r;
  logic [VW-1:0]                    den;
  logic [QW-1:0]                    hq;
  logic [VW-1:0]                    m_sel;
  logic [dfv_pkg::N_W-1:0]          prod;
  logic [dfv_pkg::N_W:0]            prod_sh;
  logic [dfv_pkg::PRE_W-1:0]        pre_r;
  logic                             ovf;
  logic [QW-1:0]                    q;
  logic                             sat;
  logic [VW-1:0]                    mag;
  dfv_pkg::out_t                    out_nxt, out_r;
  logic                             out_valid_r;

  assign adv = !out_valid_r || !out_stall;
  assign pop = adv && head_valid;

  // Stage line: valid bits and classified requests.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= S_Q; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= head_valid;
      for (int k = 1; k <= S_Q; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_r[0] <= head;
      for (int k = 1; k <= S_Q; k++) begin
        ent_r[k] <= ent_r[k-1];
      end
    end
  end

  // Bracket term T = 2^(2F+1)*dp + ds*g*h, kept as sign and magnitude.
  assign g_neg  = gravity[VW-1];
  assign g_mag  = g_neg ? VW'(-gravity) : VW'(gravity);
  assign ds_neg = ent_r[ML].ds[FW_D-1];
  assign ds_mag = ds_neg ? FW_D'(-ent_r[ML].ds) : FW_D'(ent_r[ML].ds);

  dfv_mul #(.AW(VW), .BW(MW)) u_mul_gh (
    .clk (clk), .en (adv), .a (g_mag), .b (ent_r[0].spacing), .p (p1)
  );

  dfv_mul #(.AW(FW_D), .BW(dfv_pkg::P1_W)) u_mul_dgh (
    .clk (clk), .en (adv), .a (ds_mag), .b (p1), .p (p2)
  );

  assign dp_s   = dfv_pkg::TS_W'(ent_r[S_TC-1].dp);
  assign p2_s   = (ent_r[S_TC-1].ds[FW_D-1] ^ g_neg) ?
                  -$signed({2'b00, p2}) : $signed({2'b00, p2});
  assign tc_nxt = (dp_s <<< dfv_pkg::SHIFT_T) + p2_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      tc_r       <= tc_nxt;
      tl_r[S_TM] <= '{neg: tc_r[dfv_pkg::TS_W-1],
                      mag: tc_r[dfv_pkg::TS_W-1] ? dfv_pkg::TMAG_W'(-tc_r)
                                                 : dfv_pkg::TMAG_W'(tc_r)};
      for (int k = S_TM + 1; k <= S_N; k++) begin
        tl_r[k] <= tl_r[k-1];
      end
    end
  end

  // Harmonic mean of the mobilities: floor(2*ml*mu / (ml+mu)).
  dfv_mul #(.AW(MW), .BW(MW)) u_mul_mob (
    .clk (clk), .en (adv), .a (ent_r[0].mob_lo), .b (ent_r[0].mob_up), .p (mlmu)
  );

  assign den = VW'(ent_r[ML].mob_lo) + VW'(ent_r[ML].mob_up);

  dfv_div #(.NW(dfv_pkg::HNUM_W), .DW(VW), .QW(QW)) u_div_hm (
    .clk (clk), .en (adv), .n ({mlmu, 1'b0}), .d (den), .q (hq)
  );

  always_comb begin
    if (ent_r[S_H].kind == dfv_pkg::KIND_INTERIOR) begin
      if (ent_r[S_H].mob_lo == '0 && ent_r[S_H].mob_up == '0) begin
        m_sel = '0;
      end else begin
        m_sel = hq;
      end
    end else begin
      m_sel = VW'(ent_r[S_H].mob_lo);
    end
  end

  dfv_mul #(.AW(VW), .BW(dfv_pkg::TMAG_W)) u_mul_num (
    .clk (clk), .en (adv), .a (m_sel), .b (tl_r[S_H].mag), .p (prod)
  );

  // Scale to one division by h with the quotient limited to QW bits.
  assign prod_sh = ent_r[S_N].dbl ? {prod, 1'b0} : {1'b0, prod};
  assign ovf     = pre_r >= dfv_pkg::PRE_W'({ent_r[S_PRE].spacing, {QW{1'b0}}});

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r       <= dfv_pkg::PRE_W'(prod_sh >> dfv_pkg::SHIFT_T);
      fl_r[S_PRE] <= '{nz: prod != '0, sgn: ent_r[S_N].negate ^ tl_r[S_N].neg};
      for (int k = S_PRE + 1; k <= S_Q; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
      ov_r[S_PRE+1] <= ovf;
      for (int k = S_PRE + 2; k <= S_Q; k++) begin
        ov_r[k] <= ov_r[k-1];
      end
    end
  end

  dfv_div #(.NW(dfv_pkg::PRE_W), .DW(MW), .QW(QW)) u_div_h (
    .clk (clk), .en (adv), .n (pre_r), .d (ent_r[S_PRE].spacing), .q (q)
  );

  // Rounding is already toward zero; only the range clip is left.
  always_comb begin
    sat = ov_r[S_Q] || (fl_r[S_Q].sgn ? (q > LIM_NEG) : (q > LIM_POS));
    if (sat) begin
      mag = fl_r[S_Q].sgn ? LIM_NEG : LIM_POS;
    end else begin
      mag = q;
    end
    out_nxt = '0;
    case (ent_r[S_Q].kind)
      dfv_pkg::KIND_FLUX: begin
        out_nxt.face_velocity = ent_r[S_Q].value;
      end
      dfv_pkg::KIND_INTERIOR, dfv_pkg::KIND_DIRICHLET: begin
        if (fl_r[S_Q].nz) begin
          out_nxt.face_velocity = fl_r[S_Q].sgn ? -$signed(mag) : $signed(mag);
          out_nxt.saturated     = sat;
        end
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[S_Q];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: sv/darcy_face_velocity_core.sv
// Darcy face velocity engine: one two-point-flux velocity per face request.
// Requests enter on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; a request moves at a clock edge where valid
// is high and stall is low. Each request gives exactly one result, in order.
// The spacings and gravity are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while no request is in flight, which the
// block does not enforce. Reset loads 1.0 into all four registers. The
// arithmetic runs through two 48-step pipelined dividers (harmonic mean of
// the mobilities, then the division by the spacing) and digit multipliers.
// Throughput is one request per cycle while not held: a front classifier
// fills a small request queue and the arithmetic pipeline drains it.
// When out_stall holds a waiting result, the whole pipeline holds; the queue
// keeps absorbing requests until it fills, then in_stall rises.
// Synchronous active-low reset clears the queue, the pipeline valid bits
// and the output valid flag; no request is lost or repeated across stalls.
`default_nettype none

module darcy_face_velocity_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire dfv_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output dfv_pkg::out_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [dfv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dfv_pkg::VALUE_W-1:0]       cfg_wdata
);

  localparam int MW = dfv_pkg::MOB_W;
  localparam int VW = dfv_pkg::VALUE_W;
  localparam logic [VW-1:0] ONE = VW'(1) << dfv_pkg::FRAC_W;

  logic [MW-1:0]        spacing_x_r, spacing_y_r, spacing_z_r;
  logic signed [VW-1:0] gravity_r;

  logic            push, pop, empty, full;
  dfv_pkg::entry_t entry, head;

  // Config registers; user writes only while the block is idle, unenforced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_x_r <= MW'(ONE);
      spacing_y_r <= MW'(ONE);
      spacing_z_r <= MW'(ONE);
      gravity_r   <= ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        dfv_pkg::CFG_SPACING_X: spacing_x_r <= cfg_wdata[MW-1:0];
        dfv_pkg::CFG_SPACING_Y: spacing_y_r <= cfg_wdata[MW-1:0];
        dfv_pkg::CFG_SPACING_Z: spacing_z_r <= cfg_wdata[MW-1:0];
        dfv_pkg::CFG_GRAVITY:   gravity_r   <= cfg_wdata;
        default: begin
          gravity_r <= gravity_r;
        end
      endcase
    end
  end

  // Front: classify each request into the operands of one common formula.
  dfv_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .spacing_x (spacing_x_r),
    .spacing_y (spacing_y_r),
    .spacing_z (spacing_z_r),
    .full      (full),
    .in_stall  (in_stall),
    .push      (push),
    .entry     (entry)
  );

  // The queue lets the front keep accepting while the back is held.
  dfv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // Back: exact wide arithmetic, division, rounding and saturation.
  dfv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!empty),
    .pop        (pop),
    .gravity    (gravity_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// File: dv/tb_darcy_face_velocity_core.sv
`timescale 1ns / 100ps

// Checks the face velocity core end to end. Face requests are driven with
// bursts and gaps, results are taken with random and long stalls, and every
// result is compared with a local exact-arithmetic model of the face formulas.
// The register settings are changed between phases while the core is idle.
module tb_darcy_face_velocity_core;

  localparam int VW = dfv_pkg::VALUE_W;
  localparam int MW = dfv_pkg::MOB_W;
  localparam int FW = dfv_pkg::FRAC_W;
  // Wide enough for every exact product of the face formulas.
  localparam int WIDE_W = 320;
  // Pipeline depth of the core, plus margin, used for idle waits.
  localparam int DRAIN_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  dfv_pkg::in_t in_data;
  logic out_valid;
  logic out_stall;
  dfv_pkg::out_t out_data;
  logic cfg_we;
  logic [dfv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [VW-1:0] cfg_wdata;

  // Local copy of the register file.
  logic [MW-1:0] spacing_x_r;
  logic [MW-1:0] spacing_y_r;
  logic [MW-1:0] spacing_z_r;
  logic signed [VW-1:0] gravity_r;

  // Velocities still owed by the core, oldest first.
  dfv_pkg::out_t velocity_q[$];
  int mismatch_count;
  int burst_left;
  int hold_left;
  int stall_mode;
  int stall_tick;

  darcy_face_velocity_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Exact face velocity: every formula is evaluated as one wide integer,
  // the scaling shift and the division by the spacing both truncate the
  // magnitude, and the result is clipped to the signed output range.
  function automatic dfv_pkg::out_t predict_face(dfv_pkg::in_t r);
    logic signed [WIDE_W-1:0] pl, pu, dl, du, val, grav, hh, mult, a_t, b_t, num;
    logic [WIDE_W-1:0] mag;
    logic [WIDE_W-1:0] lim;
    logic [VW-1:0] msum;
    logic [MW-1:0] h;
    bit neg;
    bit is_face;
    dfv_pkg::out_t res;
    res = '0;
    pl = $signed(r.pressure_lower);
    pu = $signed(r.pressure_upper);
    dl = $signed(r.density_lower);
    du = $signed(r.density_upper);
    val = $signed(r.boundary_value);
    grav = $signed(gravity_r);
    a_t = '0;
    b_t = '0;
    num = '0;
    h = '0;
    is_face = 1'b0;
    if (r.func == dfv_pkg::FUNC_INT_X || r.func == dfv_pkg::FUNC_INT_Y ||
        r.func == dfv_pkg::FUNC_INT_Z) begin
      h = (r.func == dfv_pkg::FUNC_INT_X) ? spacing_x_r :
          ((r.func == dfv_pkg::FUNC_INT_Y) ? spacing_y_r : spacing_z_r);
      hh = {{(WIDE_W - MW){1'b0}}, h};
      // Harmonic mean of the two mobilities; both zero gives zero.
      msum = {1'b0, r.mobility_lower} + {1'b0, r.mobility_upper};
      mag = {{(WIDE_W - MW){1'b0}}, r.mobility_lower};
      mag = mag * {{(WIDE_W - MW){1'b0}}, r.mobility_upper};
      if (msum == '0) begin
        mag = '0;
      end else begin
        mag = (mag << 1) / {{(WIDE_W - VW){1'b0}}, msum};
      end
      mult = mag;
      a_t = (pu - pl) <<< dfv_pkg::SHIFT_T;
      if (r.func == dfv_pkg::FUNC_INT_Z) begin
        b_t = (du + dl) * grav * hh;
      end
      num = -(mult * (a_t + b_t));
      is_face = 1'b1;
    end else if (r.func == dfv_pkg::FUNC_DIRICHLET &&
                 r.boundary_side <= dfv_pkg::SIDE_FRONT) begin
      h = (r.boundary_side <= dfv_pkg::SIDE_RIGHT) ? spacing_x_r :
          ((r.boundary_side <= dfv_pkg::SIDE_UP) ? spacing_y_r : spacing_z_r);
      hh = {{(WIDE_W - MW){1'b0}}, h};
      // Lower-numbered side of each pair sees value minus cell pressure.
      if (r.boundary_side[0] == 1'b0) begin
        a_t = (val - pl) <<< (dfv_pkg::SHIFT_T + 1);
      end else begin
        a_t = (pl - val) <<< (dfv_pkg::SHIFT_T + 1);
      end
      if (r.boundary_side >= dfv_pkg::SIDE_BACK) begin
        b_t = (dl * grav * hh) <<< 1;
        if (r.boundary_side == dfv_pkg::SIDE_BACK) begin
          b_t = -b_t;
        end
      end
      mult = {{(WIDE_W - MW){1'b0}}, r.mobility_lower};
      num = mult * (a_t + b_t);
      is_face = 1'b1;
    end else if (r.func == dfv_pkg::FUNC_FLUX) begin
      res.face_velocity = r.boundary_value;
    end
    if (is_face) begin
      neg = (num < 0);
      mag = neg ? -num : num;
      lim = '0;
      lim[VW-1] = 1'b1;
      if (!neg) begin
        lim = lim - 1'b1;
      end
      if (h == '0) begin
        // A zero spacing clips any nonzero numerator toward its sign.
        if (mag != '0) begin
          mag = lim;
          res.saturated = 1'b1;
        end
      end else begin
        mag = (mag >> dfv_pkg::SHIFT_T) / {{(WIDE_W - MW){1'b0}}, h};
        if (mag > lim) begin
          mag = lim;
          res.saturated = 1'b1;
        end
      end
      res.face_velocity = neg ? -mag[VW-1:0] : mag[VW-1:0];
    end
    return res;
  endfunction

  function automatic logic [VW-1:0] pick_value();
    logic [63:0] raw;
    logic [VW-1:0] v;
    raw = {$urandom, $urandom};
    v = raw[VW-1:0];
    case ($urandom_range(0, 7))
      0: v = {1'b0, {(VW - 1){1'b1}}};
      1: v = {1'b1, {(VW - 1){1'b0}}};
      2: v = '0;
      3: v = {{(VW - 28){v[27]}}, v[27:0]};
      4: v = {{(VW - 36){v[35]}}, v[35:0]};
      default: v = v;
    endcase
    return v;
  endfunction

  function automatic logic [MW-1:0] pick_mobility();
    logic [VW-1:0] v;
    v = pick_value();
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = {{(VW - 32){1'b0}}, 8'($urandom_range(0, 255)), 24'd0};
      default: v = v;
    endcase
    return v[MW-1:0];
  endfunction

  function automatic dfv_pkg::in_t random_face();
    dfv_pkg::in_t r;
    r.func = (($urandom_range(0, 19)) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
    r.boundary_side = (($urandom_range(0, 15)) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5));
    r.mobility_lower = pick_mobility();
    r.mobility_upper = pick_mobility();
    r.pressure_lower = pick_value();
    r.pressure_upper = pick_value();
    r.density_lower = pick_value();
    r.density_upper = pick_value();
    r.boundary_value = pick_value();
    return r;
  endfunction

  // Offers one request and holds it until the core takes it. Between
  // bursts the sender drops valid for a random gap, which may be zero.
  task automatic send_face(dfv_pkg::in_t r);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = r;
    do begin
      @(posedge clk);
    end while (in_stall);
    velocity_q.push_back(predict_face(r));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (velocity_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Register writes only happen with no request in flight.
  task automatic write_reg(logic [dfv_pkg::CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      dfv_pkg::CFG_SPACING_X: spacing_x_r = data[MW-1:0];
      dfv_pkg::CFG_SPACING_Y: spacing_y_r = data[MW-1:0];
      dfv_pkg::CFG_SPACING_Z: spacing_z_r = data[MW-1:0];
      default: gravity_r = data;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all(logic [MW-1:0] hx, logic [MW-1:0] hy,
                         logic [MW-1:0] hz, logic [VW-1:0] g);
    write_reg(dfv_pkg::CFG_SPACING_X, {1'b0, hx});
    write_reg(dfv_pkg::CFG_SPACING_Y, {1'b0, hy});
    write_reg(dfv_pkg::CFG_SPACING_Z, {1'b0, hz});
    write_reg(dfv_pkg::CFG_GRAVITY, g);
  endtask

  // Field extremes, each face type, every boundary side including the
  // two unused codes, the unused selectors and the zero-zero harmonic mean.
  task automatic test_directed();
    dfv_pkg::in_t r;
    logic [dfv_pkg::FUNC_W-1:0] f;
    logic [dfv_pkg::SIDE_W-1:0] s;
    r = '0;
    r.mobility_lower = 47'd1 << FW;
    r.mobility_upper = 47'd3 << FW;
    r.pressure_lower = 48'sd5 << FW;
    r.pressure_upper = -(48'sd2 << FW);
    r.density_lower = 48'sd1000 << FW;
    r.density_upper = 48'sd999 << FW;
    r.boundary_value = 48'sd7 << FW;
    for (int i = 0; i < 8; i++) begin
      f = 3'(i);
      r.func = f;
      send_face(r);
    end
    r.func = dfv_pkg::FUNC_DIRICHLET;
    for (int i = 0; i < 8; i++) begin
      s = 3'(i);
      r.boundary_side = s;
      send_face(r);
    end
    r.func = dfv_pkg::FUNC_INT_Z;
    r.mobility_lower = '0;
    r.mobility_upper = '0;
    send_face(r);
    r.mobility_lower = '1;
    r.mobility_upper = '1;
    r.pressure_lower = {1'b1, {(VW - 1){1'b0}}};
    r.pressure_upper = {1'b0, {(VW - 1){1'b1}}};
    r.density_lower = {1'b0, {(VW - 1){1'b1}}};
    r.density_upper = {1'b0, {(VW - 1){1'b1}}};
    r.boundary_value = {1'b1, {(VW - 1){1'b0}}};
    send_face(r);
    r.func = dfv_pkg::FUNC_INT_X;
    send_face(r);
    r.func = dfv_pkg::FUNC_DIRICHLET;
    r.boundary_side = dfv_pkg::SIDE_FRONT;
    send_face(r);
    r.boundary_side = dfv_pkg::SIDE_LEFT;
    send_face(r);
    r.func = dfv_pkg::FUNC_FLUX;
    r.boundary_side = 3'd7;
    send_face(r);
    r = '1;
    r.func = dfv_pkg::FUNC_FLUX;
    send_face(r);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      send_face(random_face());
    end
  endtask

  // Walks through several register settings, the extremes among them.
  task automatic test_settings();
    logic [63:0] rx, ry, rz, rg;
    set_all(47'd1, '1, 47'd3 << (FW - 1), {1'b1, {(VW - 1){1'b0}}});
    test_random(40);
    set_all('1, 47'd1, 47'd1, {1'b0, {(VW - 1){1'b1}}});
    test_random(40);
    set_all(47'd1 << (FW - 4), 47'd5 << FW, '1, '0);
    test_random(40);
    rx = {$urandom, $urandom};
    ry = {$urandom, $urandom};
    rz = {$urandom, $urandom};
    rg = {$urandom, $urandom};
    set_all(rx[MW-1:0], ry[MW-1:0], rz[MW-1:0], rg[VW-1:0]);
    if (spacing_x_r == '0) write_reg(dfv_pkg::CFG_SPACING_X, 48'd1);
    if (spacing_y_r == '0) write_reg(dfv_pkg::CFG_SPACING_Y, 48'd1);
    if (spacing_z_r == '0) write_reg(dfv_pkg::CFG_SPACING_Z, 48'd1);
    test_random(40);
    set_all(47'd1 << FW, 47'd1 << (FW + 2), 47'd1 << (FW - 2),
            -(48'sd10 << FW));
    test_random(40);
  endtask

  // The receiver holds off long enough for the core and its request queue
  // to fill, while the sender keeps offering requests.
  task automatic test_backpressure();
    hold_left = 400;
    test_random(130);
    wait_drained();
  endtask

  task automatic test_stall_patterns();
    for (int m = 0; m < 4; m++) begin
      stall_mode = m;
      test_random(40);
    end
    stall_mode = 1;
  endtask

  // Receiver: a long hold when requested, otherwise a mode-dependent
  // stall pattern, including a mode that never stalls.
  always @(negedge clk) begin
    stall_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 9) < 3);
        2: out_stall = (stall_tick % 7) < 3;
        default: out_stall = ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Each accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    dfv_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (velocity_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected result: velocity=%h saturated=%b",
                   out_data.face_velocity, out_data.saturated);
        end
      end else begin
        want = velocity_q.pop_front();
        if (out_data.face_velocity !== want.face_velocity ||
            out_data.saturated !== want.saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: velocity exp=%h got=%h, saturated exp=%b got=%b",
                     want.face_velocity, out_data.face_velocity,
                     want.saturated, out_data.saturated);
          end
        end
      end
    end
  end

  initial begin
    #60000000;
    $display("FAIL darcy_face_velocity_core");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = dfv_pkg::CFG_SPACING_X;
    cfg_wdata = '0;
    mismatch_count = 0;
    burst_left = 0;
    hold_left = 0;
    stall_mode = 1;
    stall_tick = 0;
    // Register values after reset are 1.0 throughout.
    spacing_x_r = 47'd1 << FW;
    spacing_y_r = 47'd1 << FW;
    spacing_z_r = 47'd1 << FW;
    gravity_r = 48'sd1 << FW;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_settings();
    set_all(47'd1 << FW, 47'd3 << (FW - 1), 47'd1 << (FW + 1),
            48'sd10 << FW);
    test_stall_patterns();
    test_backpressure();

    wait_drained();
    if (velocity_q.size() != 0) begin
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS darcy_face_velocity_core");
    end else begin
      $display("FAIL darcy_face_velocity_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/dfv_pkg.sv
sv/dfv_mul.sv
sv/dfv_div.sv
sv/dfv_queue.sv
sv/dfv_front.sv
sv/dfv_back.sv
sv/darcy_face_velocity_core.sv
dv/tb_darcy_face_velocity_core.sv
